/* rtl/core/artc_pkg.sv */
package artc_pkg;

    // default sizes
    localparam int COUNT_WIDTH_DEF   = 16;
    localparam int HISTORY_DEPTH_DEF = 3;

    // fixed field widths
    localparam int THR_W     = 10;
    localparam int LIMIT_W   = 16;
    localparam int MODE_W    = 2;
    localparam int PLAN_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

    localparam logic [LIMIT_W-1:0] SHORT_STAY_RESET = LIMIT_W'(5);
    localparam logic [LIMIT_W-1:0] LONG_OFF_RESET   = LIMIT_W'(100);
    localparam logic [THR_W-1:0]   FLOOR_RESET      = THR_W'(1);
    localparam logic [THR_W-1:0]   CEILING_RESET    = THR_W'(512);

    typedef enum logic [MODE_W-1:0] {
        MODE_FRAME      = 2'd0,
        MODE_TICK       = 2'd1,
        MODE_SOFT_RESET = 2'd2
    } mode_t;

    typedef enum logic [PLAN_W-1:0] {
        PLAN_OFF     = 2'd0,
        PLAN_PREPARE = 2'd1,
        PLAN_ON      = 2'd2,
        PLAN_LEAVE   = 2'd3
    } plan_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_STAY = 2'd0,
        CFG_LONG_OFF   = 2'd1,
        CFG_FLOOR      = 2'd2,
        CFG_CEILING    = 2'd3
    } cfg_idx_t;

    // history control from the event decoder
    typedef struct packed {
        logic push;
        logic clear;
    } hist_ctrl_t;

endpackage

/* rtl/core/artc_if.sv */
interface artc_in_if;
    logic                          valid;
    logic                          ready;
    logic [artc_pkg::MODE_W-1:0]   mode;
    logic                          need_leave;
    logic [artc_pkg::PLAN_W-1:0]   plan_status;
    logic                          can_direct;
    logic                          hw_enabled;

    modport source (output valid, mode, need_leave, plan_status, can_direct, hw_enabled,
                    input ready);
    modport sink   (input valid, mode, need_leave, plan_status, can_direct, hw_enabled,
                    output ready);
endinterface

interface artc_out_if;
    logic                          valid;
    logic                          ready;
    logic                          need_request;
    logic                          long_term_off;
    logic [artc_pkg::THR_W-1:0]    request_threshold;

    modport source (output valid, need_request, long_term_off, request_threshold,
                    input ready);
    modport sink   (input valid, need_request, long_term_off, request_threshold,
                    output ready);
endinterface

interface artc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [artc_pkg::CFG_IDX_W-1:0]   index;
    logic [artc_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/artc_history.sv */
module artc_history #(
    parameter int COUNT_WIDTH   = artc_pkg::COUNT_WIDTH_DEF,
    parameter int HISTORY_DEPTH = artc_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  artc_pkg::hist_ctrl_t           ctrl,
    input  logic [COUNT_WIDTH-1:0]         stay_len,
    input  logic [artc_pkg::LIMIT_W-1:0]   short_limit,
    output logic                           short_stay
);

    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = COUNT_WIDTH + $clog2(HISTORY_DEPTH);
    localparam int BND_W  = artc_pkg::LIMIT_W + $clog2(HISTORY_DEPTH);
    localparam int CMP_W  = ((SUM_W > BND_W) ? SUM_W : BND_W) + 1;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HISTORY_DEPTH);

    logic [COUNT_WIDTH-1:0] hist_reg   [HISTORY_DEPTH];
    logic [COUNT_WIDTH-1:0] hist_next  [HISTORY_DEPTH];
    logic [COUNT_WIDTH-1:0] hist_shift [HISTORY_DEPTH];
    logic [FILL_W-1:0]      fill_reg;
    logic [FILL_W-1:0]      fill_next;
    logic [SUM_W-1:0]       sum;
    logic [CMP_W-1:0]       bound;

    // oldest entry drops out, newest enters at the top
    for (genvar g = 0; g < HISTORY_DEPTH; g++)
    begin : g_shift
        if (g == HISTORY_DEPTH - 1)
        begin : g_top
            assign hist_shift[g] = stay_len;
        end
        else
        begin : g_mid
            assign hist_shift[g] = hist_reg[g + 1];
        end
    end

    always_comb
    begin
        hist_next = hist_reg;
        fill_next = fill_reg;
        if (ctrl.clear)
        begin
            fill_next = '0;
        end
        else if (ctrl.push)
        begin
            if (fill_reg == FILL_FULL)
            begin
                hist_next = hist_shift;
            end
            else
            begin
                for (int i = 0; i < HISTORY_DEPTH; i++)
                begin
                    if (FILL_W'(i) == fill_reg)
                    begin
                        hist_next[i] = stay_len;
                    end
                end
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            sum = sum + SUM_W'(hist_next[i]);
        end
    end

    // floor(sum / depth) <= limit  <=>  sum <= limit * depth + depth - 1
    assign bound = CMP_W'(short_limit) * CMP_W'(HISTORY_DEPTH) + CMP_W'(HISTORY_DEPTH - 1);

    assign short_stay = ctrl.push && !ctrl.clear && (fill_next == FILL_FULL)
                        && (CMP_W'(sum) <= bound);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hist_reg <= hist_next;
    end

endmodule

/* rtl/core/adaptive_request_threshold_controller.sv */
// Adaptive request threshold controller. Takes one event beat per clock (frame update,
// stay-on tick or soft reset) and returns exactly one result beat per event, in the cycle
// after acceptance: need_request, long_term_off and the current request threshold, all
// taken from the state as it stands after the event. Every update (saturating counters,
// the stay-on history push, the double/halve decision and the floor/ceiling clamp) is
// done in a single pass of logic into the state registers, so sustained rate is one
// event per cycle; the only thing that holds input back is a pending result beat that
// the downstream side has not taken. Configuration registers are written through the
// cfg channel, which is always ready, and must only change while no event is in flight.
module adaptive_request_threshold_controller #(
    parameter int COUNT_WIDTH   = artc_pkg::COUNT_WIDTH_DEF,
    parameter int HISTORY_DEPTH = artc_pkg::HISTORY_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    artc_in_if.sink     evt,
    artc_out_if.source  res,
    artc_cfg_if.sink    cfg
);

    localparam int THR_W  = artc_pkg::THR_W;
    localparam int LIM_W  = artc_pkg::LIMIT_W;
    localparam int WIDE_W = THR_W + 3;                              // up to three doublings
    localparam int NR_W   = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
    localparam int LO_W   = (COUNT_WIDTH > LIM_W) ? COUNT_WIDTH : LIM_W;
    localparam int RAT_W  = COUNT_WIDTH + 4;

    // configuration registers
    logic [LIM_W-1:0] short_stay_limit_reg;
    logic [LIM_W-1:0] long_off_limit_reg;
    logic [THR_W-1:0] threshold_floor_reg;
    logic [THR_W-1:0] threshold_ceiling_reg;

    // controller state
    logic [COUNT_WIDTH-1:0] no_leave_count_reg,  no_leave_count_next;
    logic [COUNT_WIDTH-1:0] stay_off_count_reg,  stay_off_count_next;
    logic [COUNT_WIDTH-1:0] stay_on_count_reg,   stay_on_count_next;
    logic [COUNT_WIDTH-1:0] no_direct_count_reg, no_direct_count_next;
    logic [COUNT_WIDTH-1:0] hw_on_count_reg,     hw_on_count_next;
    logic                   direct_expected_reg, direct_expected_next;
    logic [THR_W-1:0]       threshold_reg,       threshold_next;
    logic                   res_valid_reg;

    logic                   evt_acc;
    logic                   leave;
    logic                   short_stay;
    logic                   ratio_good;
    logic [1:0]             dbl_count;
    logic [WIDE_W-1:0]      thr_wide;
    logic [WIDE_W-1:0]      thr_clamped;
    artc_pkg::hist_ctrl_t   hist_ctrl;
    artc_pkg::mode_t        mode;
    artc_pkg::plan_t        plan;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // handshake: a result beat waits in the output register, new event enters as it leaves
    assign evt.ready = !res_valid_reg || res.ready;
    assign evt_acc   = evt.valid && evt.ready;
    assign cfg.ready = 1'b1;

    assign mode  = artc_pkg::mode_t'(evt.mode);
    assign plan  = artc_pkg::plan_t'(evt.plan_status);
    assign leave = evt_acc && (mode == artc_pkg::MODE_FRAME)
                   && (plan == artc_pkg::PLAN_LEAVE);

    assign hist_ctrl.push  = leave;
    assign hist_ctrl.clear = evt_acc && (mode == artc_pkg::MODE_SOFT_RESET);

    artc_history #(
        .COUNT_WIDTH   (COUNT_WIDTH),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (hist_ctrl),
        .stay_len    (stay_on_count_reg),
        .short_limit (short_stay_limit_reg),
        .short_stay  (short_stay)
    );

    // 2*no_direct > stay_on and 10*hw_on < 7*no_direct
    assign ratio_good = ((RAT_W'(no_direct_count_reg) << 1) > RAT_W'(stay_on_count_reg))
                        && ((RAT_W'(hw_on_count_reg) * RAT_W'(10))
                            < (RAT_W'(no_direct_count_reg) * RAT_W'(7)));

    assign dbl_count = 2'(short_stay) + 2'(!direct_expected_reg) + 2'(ratio_good);

    always_comb
    begin
        thr_wide = WIDE_W'(threshold_reg) << dbl_count;
        if (!ratio_good)
        begin
            thr_wide = thr_wide >> 1;
        end
        // floor first, then ceiling: ceiling wins when the bounds cross
        thr_clamped = thr_wide;
        if (thr_clamped < WIDE_W'(threshold_floor_reg))
        begin
            thr_clamped = WIDE_W'(threshold_floor_reg);
        end
        if (thr_clamped > WIDE_W'(threshold_ceiling_reg))
        begin
            thr_clamped = WIDE_W'(threshold_ceiling_reg);
        end
    end

    // event decode
    always_comb
    begin
        no_leave_count_next  = no_leave_count_reg;
        stay_off_count_next  = stay_off_count_reg;
        stay_on_count_next   = stay_on_count_reg;
        no_direct_count_next = no_direct_count_reg;
        hw_on_count_next     = hw_on_count_reg;
        direct_expected_next = direct_expected_reg;
        threshold_next       = threshold_reg;
        if (evt_acc)
        begin
            unique case (mode)
                artc_pkg::MODE_FRAME:
                begin
                    no_leave_count_next = evt.need_leave ? '0 : sat_inc(no_leave_count_reg);
                    unique case (plan)
                        artc_pkg::PLAN_OFF:
                        begin
                            stay_off_count_next = sat_inc(stay_off_count_reg);
                        end
                        artc_pkg::PLAN_PREPARE:
                        begin
                            stay_off_count_next = '0;
                        end
                        artc_pkg::PLAN_ON:
                        begin
                            no_direct_count_next = sat_inc(no_direct_count_reg);
                            if (evt.hw_enabled)
                            begin
                                hw_on_count_next = sat_inc(hw_on_count_reg);
                            end
                            if (evt.can_direct)
                            begin
                                direct_expected_next = 1'b0;
                            end
                        end
                        artc_pkg::PLAN_LEAVE:
                        begin
                            threshold_next       = thr_clamped[THR_W-1:0];
                            stay_on_count_next   = '0;
                            no_direct_count_next = '0;
                            hw_on_count_next     = '0;
                            direct_expected_next = 1'b1;
                        end
                        default:
                        begin
                            stay_off_count_next = stay_off_count_reg;
                        end
                    endcase
                end
                artc_pkg::MODE_TICK:
                begin
                    stay_on_count_next = sat_inc(stay_on_count_reg);
                end
                artc_pkg::MODE_SOFT_RESET:
                begin
                    threshold_next      = artc_pkg::THR_RESET;
                    stay_off_count_next = '0;
                end
                default:
                begin
                    // unused mode: state holds, result still reported
                    threshold_next = threshold_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            no_leave_count_reg  <= '0;
            stay_off_count_reg  <= '0;
            stay_on_count_reg   <= '0;
            no_direct_count_reg <= '0;
            hw_on_count_reg     <= '0;
            direct_expected_reg <= 1'b1;
            threshold_reg       <= artc_pkg::THR_RESET;
            res_valid_reg       <= 1'b0;
        end
        else
        begin
            no_leave_count_reg  <= no_leave_count_next;
            stay_off_count_reg  <= stay_off_count_next;
            stay_on_count_reg   <= stay_on_count_next;
            no_direct_count_reg <= no_direct_count_next;
            hw_on_count_reg     <= hw_on_count_next;
            direct_expected_reg <= direct_expected_next;
            threshold_reg       <= threshold_next;
            if (evt_acc)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_stay_limit_reg  <= artc_pkg::SHORT_STAY_RESET;
            long_off_limit_reg    <= artc_pkg::LONG_OFF_RESET;
            threshold_floor_reg   <= artc_pkg::FLOOR_RESET;
            threshold_ceiling_reg <= artc_pkg::CEILING_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (artc_pkg::cfg_idx_t'(cfg.index))
                artc_pkg::CFG_SHORT_STAY: short_stay_limit_reg  <= cfg.data;
                artc_pkg::CFG_LONG_OFF:   long_off_limit_reg    <= cfg.data;
                artc_pkg::CFG_FLOOR:      threshold_floor_reg   <= cfg.data[THR_W-1:0];
                artc_pkg::CFG_CEILING:    threshold_ceiling_reg <= cfg.data[THR_W-1:0];
                default:                  short_stay_limit_reg  <= short_stay_limit_reg;
            endcase
        end
    end

    // result beat reflects the state left by the last accepted event
    assign res.valid             = res_valid_reg;
    assign res.need_request      = NR_W'(no_leave_count_reg) >= NR_W'(threshold_reg);
    assign res.long_term_off     = LO_W'(stay_off_count_reg) > LO_W'(long_off_limit_reg);
    assign res.request_threshold = threshold_reg;

    // a pending result that is not taken stalls the event side
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |-> !evt.ready)
        else $error("event accepted over a stalled result");

    // soft reset returns the threshold to one
    a_soft_reset: assert property (@(posedge clk) disable iff (!rst_n)
        evt_acc && (mode == artc_pkg::MODE_SOFT_RESET) |=> threshold_reg == artc_pkg::THR_RESET)
        else $error("soft reset did not restore threshold");

    // leave frame closes the on-period counters
    a_leave_clear: assert property (@(posedge clk) disable iff (!rst_n)
        leave |=> (stay_on_count_reg == '0) && (no_direct_count_reg == '0)
                  && (hw_on_count_reg == '0) && direct_expected_reg)
        else $error("on-period counters not cleared on leave");

    // stay-on tick increments until saturation
    a_tick: assert property (@(posedge clk) disable iff (!rst_n)
        evt_acc && (mode == artc_pkg::MODE_TICK) && !(&stay_on_count_reg)
        |=> stay_on_count_reg == COUNT_WIDTH'($past(stay_on_count_reg) + 1'b1))
        else $error("stay-on tick lost");

    // every accepted event leaves a result beat behind
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        evt_acc |=> res.valid)
        else $error("accepted event produced no result");

endmodule
